// ===== hw/rtl/sdm_pkg.sv =====
// Package for the scheduled Doppler mixer: constants, types and the sine table.
`timescale 1ns / 1ps
`default_nettype none
package sdm_pkg;
   localparam int MAX_POINTS = 64;
   localparam int PT_BITS = $clog2(MAX_POINTS);
   localparam int CNT_BITS = PT_BITS + 1;
   localparam int SINE_TABLE_BITS = 10;
   localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);

   localparam logic [1:0] CSR_ENTRY_COUNT = 2'd0;
   localparam logic [1:0] CSR_BATCH_LEN   = 2'd1;
   localparam logic [1:0] CSR_START_INDEX = 2'd2;
   localparam logic [1:0] CSR_START_TIME  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_FIRST, ST_WALK_RD, ST_WALK_CHK, ST_PAIR_RD, ST_PAIR_CHK,
      ST_MUL, ST_MUL_HI, ST_DIV, ST_APPLY, ST_MIX, ST_OUT
   } state_type;

   typedef struct packed {
      logic        start;
      logic [95:0] dividend;
      logic [47:0] divisor;
   } div_cmd_type;

   typedef logic [15:0] sine_rom_type [QUARTER];

   // Q15 quarter-wave sine: polynomial evaluated at elaboration time.
   function automatic logic [15:0] quarter_sine(input int unsigned r);
      logic [63:0] u, u2, p;
      u  = 64'(r) << (30 - (SINE_TABLE_BITS - 2));
      u2 = (u * u) >> 30;
      p  = 64'd172272;
      p  = 64'd5026995 - ((u2 * p) >> 30);
      p  = 64'd85569306 - ((u2 * p) >> 30);
      p  = 64'd693598668 - ((u2 * p) >> 30);
      p  = 64'd1686629713 - ((u2 * p) >> 30);
      p  = (u * p) >> 30;
      p  = (p + 64'd16384) >> 15;
      if (p > 64'd32767) p = 64'd32767;
      return p[15:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int i = 0; i < QUARTER; i++) rom[i] = quarter_sine(i);
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();
   localparam logic [15:0] SINE_PEAK = quarter_sine(QUARTER);

   function automatic logic signed [16:0] osc_sine(input logic [SINE_TABLE_BITS-1:0] k);
      logic [1:0] quad;
      logic [SINE_TABLE_BITS-3:0] r, r_mirror;
      logic [15:0] v;
      quad     = k[SINE_TABLE_BITS-1 -: 2];
      r        = k[SINE_TABLE_BITS-3:0];
      r_mirror = ~r + 1'b1;
      // mirrored quadrant: offset zero lands on the peak, just past the table
      if (!quad[0]) v = SINE_ROM[r];
      else if (r == '0) v = SINE_PEAK;
      else v = SINE_ROM[r_mirror];
      return quad[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/sdm_divider.sv =====
// Restoring divider, one quotient bit per cycle, 96-bit dividend by 48-bit divisor.
`timescale 1ns / 1ps
`default_nettype none
module sdm_divider (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sdm_pkg::div_cmd_type cmd,
   output logic                    busy,
   output logic [63:0]             quotient
);
   import sdm_pkg::*;
   logic [95:0] num_ff, num_in;
   logic [48:0] rem_ff, rem_in;
   logic [47:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [48:0] shifted;

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      shifted = {rem_ff[47:0], num_ff[95]};
      if (cmd.start) begin
         num_in = cmd.dividend; rem_in = '0; den_in = cmd.divisor;
         cnt_in = 7'd96; busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[94:0], 1'b0};
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            num_in[0] = 1'b1;
         end else begin
            rem_in = shifted;
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quotient = num_ff[63:0];
endmodule
`default_nettype wire

// ===== hw/rtl/scheduled_doppler_mixer.sv =====
// Top level of the scheduled Doppler mixer: schedule memory, sequencer, NCO and mixer.
//
//  channel  dir  handshake          payload
//  req_     in   req_valid/stall    req_type, entry_index, entry_time, entry_step,
//                                   block_start, sample_i, sample_q
//  rsp_     out  rsp_valid/stall    out_i, out_q
//  csr_     in   csr_valid/ready    csr_index, csr_data
//
// A load is written to the schedule memory when accepted. A sample inside a chunk goes
// through the mix multiplies, then rounding into the output register. At a chunk start
// the schedule walk reads and checks each point passed, and an interpolation adds two
// partial products, then the bit-serial divider.
// Reset is synchronous; no item is taken while a result waits on a stalled rsp_.
`timescale 1ns / 1ps
`default_nettype none
module scheduled_doppler_mixer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [5:0]  entry_index,
   input  wire logic [47:0] entry_time,
   input  wire logic signed [31:0] entry_step,
   input  wire logic        block_start,
   input  wire logic signed [15:0] sample_i,
   input  wire logic signed [15:0] sample_q,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [15:0] out_i,
   output logic signed [15:0] out_q,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_data
);
   import sdm_pkg::*;

   state_type state_ff, state_in;

   logic [6:0]  entry_count_ff;
   logic [23:0] batch_len_ff;
   logic [5:0]  start_index_ff;
   logic [47:0] start_time_ff;

   logic [47:0] times_mem [MAX_POINTS];
   logic [31:0] steps_mem [MAX_POINTS];
   logic [PT_BITS-1:0] rd_addr;
   logic [47:0] rd_time_ff;
   logic [31:0] rd_step_ff;

   logic [PT_BITS-1:0] cur_ff;
   logic [47:0] sample_time_ff;
   logic [31:0] phase_ff;
   logic [31:0] step_mag_ff;
   logic        mix_down_ff;
   logic [23:0] chunk_left_ff;

   logic [47:0] t0_ff, tf_ff;
   logic signed [32:0] s0_ff, sf_ff;
   logic [15:0] xi_ff, xq_ff;
   logic signed [33:0] delta_ff;
   logic        neg_ff;
   logic [32:0] dmag_ff;
   logic [47:0] span_ff, elapsed_ff;
   logic [80:0] prod_ff;
   logic [32:0] dmag_c;
   logic [56:0] part_lo_c, part_hi_c;
   logic [80:0] prod_sum;
   logic signed [33:0] result_ff, result_in;
   logic signed [32:0] pi_ff, pq_ff, mi_ff, mq_ff;
   logic        rsp_valid_ff;
   logic signed [15:0] out_i_ff, out_q_ff;

   logic [CNT_BITS-1:0] n_used;
   logic [PT_BITS-1:0]  last_idx;
   logic                accept, is_load, need_step, cur_is_last;
   div_cmd_type div_cmd;
   logic        div_busy;
   logic [63:0] div_q;

   logic [SINE_TABLE_BITS-1:0] k, kc;
   logic signed [16:0] s_val, c_val;

   sdm_divider u_div (
      .clock(clock), .reset(reset), .cmd(div_cmd), .busy(div_busy), .quotient(div_q)
   );

   always_comb begin
      if (entry_count_ff == 7'd0) n_used = CNT_BITS'(1);
      else if (entry_count_ff > 7'(MAX_POINTS)) n_used = CNT_BITS'(MAX_POINTS);
      else n_used = entry_count_ff[CNT_BITS-1:0];
   end
   assign last_idx    = PT_BITS'(n_used - CNT_BITS'(1));
   assign cur_is_last = ({1'b0, cur_ff} + CNT_BITS'(1)) >= n_used;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign is_load   = !req_type;
   assign need_step = block_start || (chunk_left_ff == 24'd0);
   assign csr_ready = (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (accept && !is_load) state_in = need_step ? ST_RD_FIRST : ST_MIX;
         ST_RD_FIRST: state_in = ST_WALK_RD;
         ST_WALK_RD:  state_in = ST_WALK_CHK;
         ST_WALK_CHK: begin
            if (!cur_is_last && sample_time_ff >= rd_time_ff) state_in = ST_WALK_RD;
            else state_in = ST_PAIR_RD;
         end
         ST_PAIR_RD:  state_in = ST_PAIR_CHK;
         ST_PAIR_CHK: begin
            if (sample_time_ff <= t0_ff || cur_is_last || sample_time_ff <= tf_ff
                || sample_time_ff >= rd_time_ff) state_in = ST_APPLY;
            else state_in = ST_MUL;
         end
         ST_MUL:      state_in = ST_MUL_HI;
         ST_MUL_HI:   state_in = ST_DIV;
         ST_DIV:      if (!div_busy) state_in = ST_APPLY;
         ST_APPLY:    state_in = ST_MIX;
         ST_MIX:      state_in = ST_OUT;
         ST_OUT:      state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // memory read address per state
   always_comb begin
      unique case (state_ff)
         ST_IDLE:    rd_addr = '0;
         ST_WALK_RD: rd_addr = cur_ff + PT_BITS'(1);
         // past the end, read the last point's step instead
         ST_WALK_CHK: rd_addr = cur_is_last ? last_idx : cur_ff;
         ST_PAIR_RD: rd_addr = cur_ff + PT_BITS'(1);
         ST_RD_FIRST: rd_addr = '0;
         default:    rd_addr = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && is_load && (int'(entry_index) < MAX_POINTS)) begin
         times_mem[entry_index[PT_BITS-1:0]] <= entry_time;
         steps_mem[entry_index[PT_BITS-1:0]] <= entry_step;
      end
      rd_time_ff <= times_mem[rd_addr];
      rd_step_ff <= steps_mem[rd_addr];
   end

   // interpolation result selection
   always_comb begin
      result_in = result_ff;
      if (state_ff == ST_PAIR_CHK) begin
         if (sample_time_ff <= t0_ff) result_in = 34'(s0_ff);
         else if (cur_is_last) result_in = 34'(sf_ff);
         else if (sample_time_ff <= tf_ff) result_in = 34'(sf_ff);
         else if (sample_time_ff >= rd_time_ff) result_in = 34'($signed(rd_step_ff));
      end else if (state_ff == ST_DIV && !div_busy) begin
         result_in = neg_ff ? 34'(sf_ff) - $signed({1'b0, div_q[32:0]})
                            : 34'(sf_ff) + $signed({1'b0, div_q[32:0]});
      end
   end

   assign div_cmd.start    = (state_ff == ST_MUL_HI);
   assign div_cmd.dividend = {15'd0, prod_sum};
   assign div_cmd.divisor  = span_ff;

   assign k     = phase_ff[31 -: SINE_TABLE_BITS];
   assign kc    = k + SINE_TABLE_BITS'(QUARTER);
   assign s_val = osc_sine(k);
   assign c_val = osc_sine(kc);

   function automatic logic signed [15:0] rq15(input logic signed [33:0] v);
      logic signed [34:0] r;
      r = ($signed({v[33], v}) + 35'sd16384) >>> 15;
      if (r > 35'sd32767) return 16'sh7fff;
      if (r < -35'sd32768) return 16'sh8000;
      return r[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= 7'd1;
         batch_len_ff   <= 24'd1;
         start_index_ff <= '0;
         start_time_ff  <= '0;
         cur_ff         <= '0;
         sample_time_ff <= '0;
         phase_ff       <= '0;
         step_mag_ff    <= '0;
         mix_down_ff    <= 1'b0;
         chunk_left_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ENTRY_COUNT: entry_count_ff <= csr_data[6:0];
               CSR_BATCH_LEN:   batch_len_ff <= csr_data[23:0];
               CSR_START_INDEX: begin
                  start_index_ff <= csr_data[5:0];
                  cur_ff <= csr_data[PT_BITS-1:0];
               end
               CSR_START_TIME: begin
                  start_time_ff <= csr_data;
                  sample_time_ff <= csr_data;
               end
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_WALK_CHK && !cur_is_last && sample_time_ff >= rd_time_ff)
            cur_ff <= cur_ff + PT_BITS'(1);
         if (state_ff == ST_APPLY) begin
            mix_down_ff   <= result_ff[33];
            step_mag_ff   <= result_ff[33] ? 32'(-result_ff) : result_ff[31:0];
            chunk_left_ff <= (batch_len_ff == 24'd0) ? 24'd1 : batch_len_ff;
         end
         if (state_ff == ST_OUT) begin
            rsp_valid_ff   <= 1'b1;
            phase_ff       <= phase_ff + step_mag_ff;
            sample_time_ff <= sample_time_ff + 48'd1;
            chunk_left_ff  <= chunk_left_ff - 24'd1;
         end
      end
      if (accept) begin
         xi_ff <= sample_i;
         xq_ff <= sample_q;
      end
      if (state_ff == ST_RD_FIRST) begin
         t0_ff <= rd_time_ff;
         s0_ff <= $signed(rd_step_ff);
      end
      if (state_ff == ST_PAIR_RD) begin
         tf_ff <= rd_time_ff;
         sf_ff <= $signed(rd_step_ff);
      end
      if (state_ff == ST_PAIR_CHK) begin
         delta_ff   <= 34'($signed(rd_step_ff)) - 34'(sf_ff);
         span_ff    <= rd_time_ff - tf_ff;
         elapsed_ff <= sample_time_ff - tf_ff;
      end
      if (state_ff == ST_MUL) begin
         neg_ff <= delta_ff[33];
      end
      result_ff <= result_in;
      if (state_ff == ST_MIX) begin
         pi_ff <= $signed(xi_ff) * c_val;
         pq_ff <= $signed(xq_ff) * s_val;
         mi_ff <= $signed(xi_ff) * s_val;
         mq_ff <= $signed(xq_ff) * c_val;
      end
      if (state_ff == ST_OUT) begin
         if (mix_down_ff) begin
            out_i_ff <= rq15(34'(pi_ff) + 34'(pq_ff));
            out_q_ff <= rq15(34'(mq_ff) - 34'(mi_ff));
         end else begin
            out_i_ff <= rq15(34'(pi_ff) - 34'(pq_ff));
            out_q_ff <= rq15(34'(mi_ff) + 34'(mq_ff));
         end
      end
   end

   // magnitude product, registered before the divider (cut into two partials)
   assign dmag_c    = delta_ff[33] ? 33'(-delta_ff) : delta_ff[32:0];
   assign part_lo_c = dmag_c * elapsed_ff[23:0];
   assign part_hi_c = dmag_ff * elapsed_ff[47:24];
   assign prod_sum  = prod_ff + {part_hi_c, 24'd0};
   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         dmag_ff <= dmag_c;
         prod_ff <= 81'(part_lo_c);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign out_i     = out_i_ff;
   assign out_q     = out_q_ff;
endmodule
`default_nettype wire

// ===== tb/sdm_checker.sv =====
// Checker for the scheduled Doppler mixer: watches all channels, predicts and compares results.
`timescale 1ns / 1ps
module sdm_checker
   import sdm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_type,
   input  logic [5:0]         entry_index,
   input  logic [47:0]        entry_time,
   input  logic signed [31:0] entry_step,
   input  logic               block_start,
   input  logic signed [15:0] sample_i,
   input  logic signed [15:0] sample_q,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] out_i,
   input  logic signed [15:0] out_q,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [47:0]        csr_data,
   output int                 fails,
   output int                 pending
);
   typedef struct {
      logic signed [15:0] i;
      logic signed [15:0] q;
   } mixed_type;

   mixed_type mixed_q[$];

   // schedule and configuration copies
   logic [47:0]        sched_time [MAX_POINTS];
   logic signed [31:0] sched_step [MAX_POINTS];
   logic [6:0]         cfg_count;
   logic [23:0]        cfg_batch;
   logic [5:0]         cfg_sidx;
   logic [47:0]        cfg_stime;
   // oscillator state
   int                 walk_idx;
   logic [47:0]        tick;
   logic [31:0]        phase;
   logic [31:0]        step_mag;
   logic               mixing_down;
   logic [23:0]        chunk_rem;

   // snapshots taken at the rising edge
   logic s_rst, s_req, s_rsp, s_csr, s_type, s_bs;
   logic [5:0] s_idx;
   logic [47:0] s_time, s_cdata;
   logic signed [31:0] s_step;
   logic signed [15:0] s_si, s_sq, s_oi, s_oq;
   logic [1:0] s_cidx;

   always @(posedge clock) begin
      s_rst  <= reset;
      s_req  <= req_valid && !req_stall;
      s_rsp  <= rsp_valid && !rsp_stall;
      s_csr  <= csr_valid && csr_ready;
      s_type <= req_type;
      s_idx  <= entry_index;
      s_time <= entry_time;
      s_step <= entry_step;
      s_bs   <= block_start;
      s_si   <= sample_i;
      s_sq   <= sample_q;
      s_oi   <= out_i;
      s_oq   <= out_q;
      s_cidx <= csr_index;
      s_cdata <= csr_data;
   end

   function automatic longint quarter_wave(int r);
      logic [63:0] u, u2, acc;
      u   = 64'(r) << (30 - (SINE_TABLE_BITS - 2));
      u2  = (u * u) >> 30;
      acc = 64'd172272;
      acc = 64'd5026995 - ((u2 * acc) >> 30);
      acc = 64'd85569306 - ((u2 * acc) >> 30);
      acc = 64'd693598668 - ((u2 * acc) >> 30);
      acc = 64'd1686629713 - ((u2 * acc) >> 30);
      acc = (u * acc) >> 30;
      acc = (acc + 64'd16384) >> 15;
      if (acc > 64'd32767) acc = 64'd32767;
      return longint'(acc);
   endfunction

   function automatic longint nco_sine(int k);
      int quad, r;
      longint v;
      quad = (k >> (SINE_TABLE_BITS - 2)) & 3;
      r    = k & (QUARTER - 1);
      v    = (quad & 1) ? quarter_wave(QUARTER - r) : quarter_wave(r);
      return (quad & 2) ? -v : v;
   endfunction

   function automatic longint to_q15(longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   // walk past reached points, then interpolate the step with a truncating divide
   function automatic longint interp_step();
      int n;
      longint sf, st, delta;
      logic [47:0] tf, tt;
      logic [95:0] num, quot;
      n = (cfg_count == 0) ? 1 : ((cfg_count > MAX_POINTS) ? MAX_POINTS : int'(cfg_count));
      while (walk_idx + 1 < n && tick >= sched_time[walk_idx + 1]) walk_idx++;
      if (tick <= sched_time[0]) return longint'(sched_step[0]);
      if (walk_idx >= n - 1) return longint'(sched_step[n - 1]);
      tf = sched_time[walk_idx];
      tt = sched_time[walk_idx + 1];
      sf = longint'(sched_step[walk_idx]);
      st = longint'(sched_step[walk_idx + 1]);
      if (tick <= tf) return sf;
      if (tick >= tt) return st;
      delta = st - sf;
      num   = 96'(delta < 0 ? -delta : delta) * 96'(tick - tf);
      quot  = num / 96'(tt - tf);
      return (delta < 0) ? sf - longint'(quot) : sf + longint'(quot);
   endfunction

   initial begin
      fails = 0;
      pending = 0;
   end

   always @(negedge clock) begin
      longint st, xi, xq, sn, cs, yi, yq;
      int k;
      mixed_type got, want;
      if (s_rst) begin
         mixed_q.delete();
         cfg_count = 7'd1;
         cfg_batch = 24'd1;
         cfg_sidx = '0;
         cfg_stime = '0;
         walk_idx = 0;
         tick = '0;
         phase = '0;
         step_mag = '0;
         mixing_down = 1'b0;
         chunk_rem = '0;
      end else begin
         if (s_rsp) begin
            got.i = s_oi;
            got.q = s_oq;
            if (mixed_q.size() == 0) begin
               $error("unexpected transaction out_i=%0d out_q=%0d", got.i, got.q);
               fails++;
            end else begin
               want = mixed_q.pop_front();
               if (got.i !== want.i) begin
                  $error("out_i expected %0d actual %0d", want.i, got.i);
                  fails++;
               end
               if (got.q !== want.q) begin
                  $error("out_q expected %0d actual %0d", want.q, got.q);
                  fails++;
               end
            end
         end
         if (s_csr) begin
            case (s_cidx)
               CSR_ENTRY_COUNT: cfg_count = s_cdata[6:0];
               CSR_BATCH_LEN:   cfg_batch = s_cdata[23:0];
               CSR_START_INDEX: begin
                  cfg_sidx = s_cdata[5:0];
                  walk_idx = int'(cfg_sidx);
               end
               CSR_START_TIME: begin
                  cfg_stime = s_cdata;
                  tick = cfg_stime;
               end
               default: ;
            endcase
         end
         if (s_req) begin
            if (!s_type) begin
               sched_time[s_idx] = s_time;
               sched_step[s_idx] = s_step;
            end else begin
               if (s_bs || chunk_rem == 0) begin
                  st = interp_step();
                  mixing_down = st < 0;
                  step_mag = 32'(st < 0 ? -st : st);
                  chunk_rem = (cfg_batch == 0) ? 24'd1 : cfg_batch;
               end
               xi = longint'(s_si);
               xq = longint'(s_sq);
               k  = int'(phase[31 -: SINE_TABLE_BITS]);
               sn = nco_sine(k);
               cs = nco_sine((k + QUARTER) & ((1 << SINE_TABLE_BITS) - 1));
               if (mixing_down) begin
                  yi = xi * cs + xq * sn;
                  yq = xq * cs - xi * sn;
               end else begin
                  yi = xi * cs - xq * sn;
                  yq = xi * sn + xq * cs;
               end
               want.i = 16'(to_q15(yi));
               want.q = 16'(to_q15(yq));
               mixed_q.push_back(want);
               phase = phase + step_mag;
               tick = tick + 48'd1;
               chunk_rem = chunk_rem - 24'd1;
            end
         end
      end
      pending = mixed_q.size();
   end
endmodule

// ===== tb/tb_scheduled_doppler_mixer.sv =====
// Top of the scheduled Doppler mixer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_scheduled_doppler_mixer;
   import sdm_pkg::*;

   logic clock, reset;
   logic req_valid, req_stall, req_type, block_start;
   logic [5:0] entry_index;
   logic [47:0] entry_time;
   logic signed [31:0] entry_step;
   logic signed [15:0] sample_i, sample_q, out_i, out_q;
   logic rsp_valid, rsp_stall;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [47:0] csr_data;
   int fails, pending;
   logic req_took, csr_took;
   logic calm, long_hold;

   scheduled_doppler_mixer u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .entry_index(entry_index), .entry_time(entry_time), .entry_step(entry_step),
      .block_start(block_start), .sample_i(sample_i), .sample_q(sample_q),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .out_i(out_i), .out_q(out_q),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   sdm_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .entry_index(entry_index), .entry_time(entry_time), .entry_step(entry_step),
      .block_start(block_start), .sample_i(sample_i), .sample_q(sample_q),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .out_i(out_i), .out_q(out_q),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .fails(fails), .pending(pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      req_took <= req_valid && !req_stall;
      csr_took <= csr_valid && csr_ready;
   end

   initial begin
      #40ms;
      $display("scheduled_doppler_mixer: mismatch");
      $finish;
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!calm && !reset && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push(input logic typ, input logic [5:0] idx, input logic [47:0] tm,
                       input logic [31:0] stp, input logic bs,
                       input logic [15:0] si, input logic [15:0] sq);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_type    <= typ;
      entry_index <= idx;
      entry_time  <= tm;
      entry_step  <= stp;
      block_start <= bs;
      sample_i    <= si;
      sample_q    <= sq;
      req_valid   <= 1'b1;
      do @(negedge clock); while (!req_took);
   endtask

   task automatic mix(input logic bs, input logic [15:0] si, input logic [15:0] sq);
      push(1'b1, 6'($urandom), 48'({$urandom, $urandom}), $urandom, bs, si, sq);
   endtask

   task automatic load(input logic [5:0] idx, input logic [47:0] tm, input logic [31:0] stp);
      push(1'b0, idx, tm, stp, 1'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // hold until every result is back, then let a pending chunk start finish
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (300) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [47:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_took);
   endtask

   function automatic logic [31:0] rand_step();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed(16'($urandom)));
         2: return 32'($urandom_range(0, 50000));
         default: return -32'($urandom_range(0, 50000));
      endcase
   endfunction

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [6:0]  p_count [8];
      logic [23:0] p_batch [8];
      logic [5:0]  p_sidx  [8];
      logic [47:0] p_stime [8];
      logic [47:0] t;
      int n;
      p_count = '{7'd8, 7'd64, 7'd0, 7'd127, 7'd1, 7'd16, 7'd5, 7'd12};
      p_batch = '{24'd1, 24'd4, 24'd0, 24'hFFFFFF, 24'd3, 24'd2, 24'd7, 24'd1};
      p_sidx  = '{6'd0, 6'd0, 6'd63, 6'd5, 6'd0, 6'd20, 6'd2, 6'd0};
      p_stime = '{48'd0, 48'd1000, 48'hFFFF_FFFF_FFF0, 48'd50, 48'd0,
                  48'h8000_0000_0000, 48'd300, 48'd0};
      reset = 1'b1;
      calm = 1'b0;
      long_hold = 1'b0;
      req_valid = 1'b0;
      req_type = 1'b0;
      entry_index = '0;
      entry_time = '0;
      entry_step = '0;
      block_start = 1'b0;
      sample_i = '0;
      sample_q = '0;
      csr_valid = 1'b0;
      csr_index = CSR_ENTRY_COUNT;
      csr_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill every slot so that no walk ever reads an unwritten point
      for (int s = 0; s < MAX_POINTS; s++) load(6'(s), 48'(s * 5), rand_step());

      for (int ph = 0; ph < 8; ph++) begin
         calm = (ph == 7);
         drain();
         csr_write(CSR_ENTRY_COUNT, 48'(p_count[ph]));
         csr_write(CSR_BATCH_LEN, 48'(p_batch[ph]));
         csr_write(CSR_START_INDEX, 48'(p_sidx[ph]));
         csr_write(CSR_START_TIME, p_stime[ph]);
         csr_valid <= 1'b0;

         // schedule around the start tick, mostly rising, with some repeated times
         n = (p_count[ph] == 0) ? 1 : ((p_count[ph] > MAX_POINTS) ? MAX_POINTS : p_count[ph]);
         t = p_stime[ph] - 48'd10;
         for (int s = 0; s < n; s++) begin
            load(6'(s), t, rand_step());
            t = t + 48'($urandom_range(0, 20));
         end

         if (ph == 0) begin
            load(6'd1, 48'd0, 32'h8000_0000);
            load(6'd2, 48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF);
            mix(1'b1, 16'h8000, 16'h8000);
            mix(1'b0, 16'h7FFF, 16'h7FFF);
            mix(1'b0, 16'h8000, 16'h7FFF);
            mix(1'b1, 16'h7FFF, 16'h8000);
            mix(1'b0, 16'h0000, 16'h0000);
            load(6'd1, 48'd3, 32'h8000_0000);
            load(6'd2, 48'd9, 32'h7FFF_FFFF);
            for (int j = 0; j < 10; j++) mix(1'($urandom_range(0, 1)), rand_sample(),
                                             rand_sample());
         end

         for (int j = 0; j < 190; j++) begin
            if (ph == 1 && j == 60) long_hold = 1'b1;
            if (ph == 4 && j == 90) drain();
            if ($urandom_range(0, 99) < 85) begin
               mix($urandom_range(0, 15) == 0, rand_sample(), rand_sample());
            end else if ($urandom_range(0, 7) == 0) begin
               load(6'($urandom), {16'($urandom), $urandom}, $urandom);
            end else begin
               load(6'($urandom_range(0, n - 1)),
                    p_stime[ph] + 48'($urandom_range(0, 400)), rand_step());
            end
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (300) @(posedge clock);
      if (fails == 0)
         $display("scheduled_doppler_mixer: match");
      else
         $display("scheduled_doppler_mixer: mismatch");
      $finish;
   end
endmodule

// ===== scheduled_doppler_mixer.f =====
hw/rtl/sdm_pkg.sv
hw/rtl/sdm_divider.sv
hw/rtl/scheduled_doppler_mixer.sv
tb/sdm_checker.sv
tb/tb_scheduled_doppler_mixer.sv
